>>> hw/rtl/rotate_mask_merge_extend_uop_top_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ROTATE_MASK_MERGE_EXTEND_UOP_TOP_MACROS_SVH
`define ROTATE_MASK_MERGE_EXTEND_UOP_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define RMME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define RMME_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`else

`define RMME_ASSERT(label, prop, msg)

`define RMME_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> hw/rtl/rmme_pkg.sv
`default_nettype none

package rmme_pkg;

    localparam int unsigned DataW = 64;
    localparam int unsigned CntW  = 6;
    localparam int unsigned TopW  = 7;
    localparam int unsigned FlagW = 8;
    localparam int unsigned InW   = 152;
    localparam int unsigned OutW  = 72;

    localparam int unsigned FLAG_SF = 7;
    localparam int unsigned FLAG_ZF = 6;
    localparam int unsigned FLAG_PF = 2;

    typedef enum logic [1:0] {
        SIZE_B1 = 2'd0,
        SIZE_B2 = 2'd1,
        SIZE_B4 = 2'd2,
        SIZE_B8 = 2'd3
    } size_t;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_ZERO = 2'd1,
        EXT_SIGN = 2'd2
    } ext_t;

    // base, rotated source, insert mask, field top, size and extend mode
    typedef struct packed {
        logic [DataW-1:0] base;
        logic [DataW-1:0] rot;
        logic [DataW-1:0] mask;
        logic [TopW-1:0]  top;
        size_t            size;
        logic [1:0]       ext;
    } rmme_s1_t;

    // merged and extended value ready for sizing
    typedef struct packed {
        logic [DataW-1:0] base;
        logic [DataW-1:0] tx;
        size_t            size;
    } rmme_s2_t;

    // laid out as m_tdata: flags above the value
    typedef struct packed {
        logic [FlagW-1:0] flags;
        logic [DataW-1:0] value;
    } rmme_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rmme_rotmask.sv
`default_nettype none

module rmme_rotmask (
    input  wire logic [rmme_pkg::DataW-1:0] base_value,
    input  wire logic [rmme_pkg::DataW-1:0] source_value,
    input  wire logic [rmme_pkg::CntW-1:0]  mask_start,
    input  wire logic [rmme_pkg::CntW-1:0]  mask_count,
    input  wire logic [rmme_pkg::CntW-1:0]  rotate_count,
    input  wire logic [1:0]                 size_code,
    input  wire logic [1:0]                 extend_mode,
    output rmme_pkg::rmme_s1_t              s1
);
    import rmme_pkg::*;

    logic [2*DataW-1:0] src_dbl;
    logic [2*DataW-1:0] msk_dbl;
    logic [DataW-1:0]   ones;

    always_comb begin
        // right rotate via doubled word
        src_dbl = {source_value, source_value} >> rotate_count;
        ones    = (DataW'(1) << mask_count) - DataW'(1);
        // left rotate of the run of ones, wrapping past the top bit
        msk_dbl = {ones, ones} << mask_start;

        s1.base = base_value;
        s1.rot  = src_dbl[DataW-1:0];
        s1.mask = msk_dbl[2*DataW-1:DataW];
        s1.top  = {1'b0, mask_start} + {1'b0, mask_count};
        s1.size = size_t'(size_code);
        s1.ext  = extend_mode;
    end

endmodule

`default_nettype wire

>>> hw/rtl/rmme_size_flags.sv
`default_nettype none

module rmme_size_flags (
    input  wire logic [rmme_pkg::DataW-1:0] base_value,
    input  wire logic [rmme_pkg::DataW-1:0] tx,
    input  wire rmme_pkg::size_t            size,
    output rmme_pkg::rmme_res_t             res
);
    import rmme_pkg::*;

    logic [DataW-1:0] z;
    logic             sf;
    logic             zf;

    always_comb begin
        case (size)
            SIZE_B1: begin
                z  = {base_value[DataW-1:8], tx[7:0]};
                sf = z[7];
                zf = (z[7:0] == 8'h00);
            end
            SIZE_B2: begin
                z  = {base_value[DataW-1:16], tx[15:0]};
                sf = z[15];
                zf = (z[15:0] == 16'h0000);
            end
            SIZE_B4: begin
                // 4-byte writes clear the upper half
                z  = {32'h0, tx[31:0]};
                sf = z[31];
                zf = (z[31:0] == 32'h0);
            end
            default: begin
                z  = tx;
                sf = z[DataW-1];
                zf = (z == '0);
            end
        endcase

        res.value          = z;
        res.flags          = '0;
        res.flags[FLAG_SF] = sf;
        res.flags[FLAG_ZF] = zf;
        res.flags[FLAG_PF] = ~^z[7:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/rotate_mask_merge_extend_uop_top.sv
// rotate, mask, merge and extend uop with x86 style flags
//
// s_ channel: one operation per transfer on s_tdata; m_ channel: one result
// per transfer on m_tdata (64-bit value, flags byte above it with SF bit 7
// and ZF bit 6 computed at the selected operand size, PF bit 2 from the low byte).
// every accepted operation gives exactly one result, in order.
// an accepted operation is registered in turn through the stages rotate and
// mask build, merge and extend, size select and flags, and m_tvalid is the
// valid bit of the last stage.
// throughput: one operation per cycle while m_tready stays high.
// the stage registers carry their own valid bits, so an empty stage takes a
// new item even while a later one waits; when m_tready is low the result
// holds on m_tdata and the pipe fills up behind it, at most three items,
// after which s_tready drops. nothing is lost or duplicated across a stall.
// aresetn (synchronous, active low) empties all stages; m_tvalid is low
// the cycle after reset and s_tready is high as soon as reset is released.
`default_nettype none

`include "rotate_mask_merge_extend_uop_top_macros.svh"

module rotate_mask_merge_extend_uop_top (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // base_value, source_value, mask_start, mask_count, rotate_count,
    // size_code, extend_mode, 2 zero pad bits
    input  wire logic [rmme_pkg::InW-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // result_value, flag_bits
    output logic [rmme_pkg::OutW-1:0]     m_tdata
);
    import rmme_pkg::*;

    // stage valids and payloads
    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      v3_reg, v3_next;
    rmme_s1_t  s1_reg, s1_next;
    rmme_s2_t  s2_reg, s2_next;
    rmme_res_t res_reg, res_next;

    logic      rdy1, rdy2, rdy3;
    rmme_s1_t  s1_calc;
    rmme_res_t res_calc;

    logic [DataW-1:0] t;
    logic [DataW-1:0] zmask;
    logic [TopW-1:0]  tidx;
    logic             sbit;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg;

    rmme_rotmask u_rotmask (
        .base_value   (s_tdata[63:0]),
        .source_value (s_tdata[127:64]),
        .mask_start   (s_tdata[133:128]),
        .mask_count   (s_tdata[139:134]),
        .rotate_count (s_tdata[145:140]),
        .size_code    (s_tdata[147:146]),
        .extend_mode  (s_tdata[149:148]),
        .s1           (s1_calc)
    );

    // merge and extend
    always_comb begin
        t     = (s1_reg.base & ~s1_reg.mask) | (s1_reg.rot & s1_reg.mask);
        zmask = s1_reg.top[CntW] ? '1 : ((DataW'(1) << s1_reg.top[CntW-1:0]) - DataW'(1));
        tidx  = s1_reg.top - TopW'(1);
        // no field top when the field is empty at bit zero or lies past bit 63
        sbit  = (s1_reg.top != '0) && (s1_reg.top <= TopW'(DataW)) ?
                t[tidx[CntW-1:0]] : 1'b0;

        s2_next.base = s1_reg.base;
        s2_next.size = s1_reg.size;
        case (s1_reg.ext)
            EXT_ZERO: s2_next.tx = t & zmask;
            EXT_SIGN: s2_next.tx = sbit ? (t | ~zmask) : (t & zmask);
            default:  s2_next.tx = t;
        endcase
    end

    rmme_size_flags u_size_flags (
        .base_value (s2_reg.base),
        .tx         (s2_reg.tx),
        .size       (s2_reg.size),
        .res        (res_calc)
    );

    always_comb begin
        v1_next  = rdy1 ? s_tvalid : v1_reg;
        v2_next  = rdy2 ? v1_reg : v2_reg;
        v3_next  = rdy3 ? v2_reg : v3_reg;
        s1_next  = s1_calc;
        res_next = res_calc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg) begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg) begin
            res_reg <= res_next;
        end
    end

    `RMME_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !v1_reg && !v2_reg && !v3_reg, "pipe not empty after reset")
    `RMME_ASSERT(a_empty_head_ready, !v1_reg |-> s_tready, "input stalled with empty first stage")
    `RMME_ASSERT(a_stage_advance, v1_reg && rdy2 |=> v2_reg, "item lost between stages")
    `RMME_ASSERT(a_zf_low_byte, m_tvalid && m_tdata[70] |-> m_tdata[7:0] == 8'h00, "zf set with nonzero low byte")
    `RMME_ASSERT(a_pf_parity, m_tvalid |-> m_tdata[66] == ~^m_tdata[7:0], "pf does not match low byte parity")
    `RMME_ASSERT(a_unused_flags, m_tvalid |-> m_tdata[69:67] == 3'b000 && m_tdata[65:64] == 2'b00, "reserved flag bits set")

endmodule

`default_nettype wire

>>> bench/rotate_mask_merge_extend_uop_top_tb.sv
`timescale 1ns / 100ps

module rotate_mask_merge_extend_uop_top_tb;

    import rmme_pkg::*;

    // one operation as it sits on s_tdata, last member in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  ext;
        size_t       size;
        logic [5:0]  rot;
        logic [5:0]  cnt;
        logic [5:0]  start;
        logic [63:0] src;
        logic [63:0] base;
    } merge_op_t;

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [InW-1:0]   s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OutW-1:0]  m_tdata;

    merge_op_t        pending_ops[$];
    rmme_res_t        expected_results[$];
    rmme_res_t        got_res;
    rmme_res_t        want_res;
    int               mismatch_count = 0;
    int               accepted_count = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;
    logic             hold_off = 1'b0;
    logic             in_fire = 1'b0;

    rotate_mask_merge_extend_uop_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // rotate, insert under the wrapped mask, extend, then size and flag
    function automatic rmme_res_t predict_result(merge_op_t op);
        logic [127:0] wide;
        logic [63:0]  rot_src;
        logic [63:0]  ins_mask;
        logic [63:0]  merged;
        logic [63:0]  fill_mask;
        logic [63:0]  ext_val;
        logic [6:0]   top;
        logic         sign;
        logic         sf;
        logic         zf;
        rmme_res_t    r;
        wide = {op.src, op.src} >> op.rot;
        rot_src = wide[63:0];
        ins_mask = (64'd1 << op.cnt) - 64'd1;
        wide = {ins_mask, ins_mask} << op.start;
        ins_mask = wide[127:64];
        merged = (op.base & ~ins_mask) | (rot_src & ins_mask);
        top = {1'b0, op.start} + {1'b0, op.cnt};
        fill_mask = (top >= 7'd64) ? '1 : ((64'd1 << top) - 64'd1);
        // no field top when the field is empty at bit zero or lies past bit 63
        sign = (top != 7'd0 && top <= 7'd64) ? merged[top - 7'd1] : 1'b0;
        case (op.ext)
            EXT_ZERO: ext_val = merged & fill_mask;
            EXT_SIGN: ext_val = sign ? (merged | ~fill_mask) : (merged & fill_mask);
            default:  ext_val = merged;
        endcase
        case (op.size)
            SIZE_B1: begin
                r.value = {op.base[63:8], ext_val[7:0]};
                sf = ext_val[7];
                zf = (ext_val[7:0] == 8'd0);
            end
            SIZE_B2: begin
                r.value = {op.base[63:16], ext_val[15:0]};
                sf = ext_val[15];
                zf = (ext_val[15:0] == 16'd0);
            end
            SIZE_B4: begin
                r.value = {32'd0, ext_val[31:0]};
                sf = ext_val[31];
                zf = (ext_val[31:0] == 32'd0);
            end
            default: begin
                r.value = ext_val;
                sf = ext_val[63];
                zf = (ext_val == 64'd0);
            end
        endcase
        r.flags = '0;
        r.flags[FLAG_SF] = sf;
        r.flags[FLAG_ZF] = zf;
        r.flags[FLAG_PF] = ~^r.value[7:0];
        return r;
    endfunction

    function automatic merge_op_t make_op(logic [63:0] base, logic [63:0] src,
                                          int start, int cnt, int rot,
                                          size_t size, logic [1:0] ext);
        merge_op_t op;
        op.pad   = 2'b00;
        op.base  = base;
        op.src   = src;
        op.start = start[5:0];
        op.cnt   = cnt[5:0];
        op.rot   = rot[5:0];
        op.size  = size;
        op.ext   = ext;
        return op;
    endfunction

    task automatic queue_random_ops(int n);
        merge_op_t op;
        for (int i = 0; i < n; i++) begin
            op.pad = 2'b00;
            case ($urandom_range(7))
                0:       op.base = '0;
                1:       op.base = '1;
                default: op.base = {$urandom, $urandom};
            endcase
            case ($urandom_range(7))
                0:       op.src = '0;
                1:       op.src = '1;
                default: op.src = {$urandom, $urandom};
            endcase
            case ($urandom_range(5))
                0:       op.start = 6'd0;
                1:       op.start = 6'd63;
                default: op.start = 6'($urandom_range(63));
            endcase
            case ($urandom_range(5))
                0:       op.cnt = 6'd0;
                1:       op.cnt = 6'd63;
                default: op.cnt = 6'($urandom_range(63));
            endcase
            case ($urandom_range(5))
                0:       op.rot = 6'd0;
                1:       op.rot = 6'd63;
                default: op.rot = 6'($urandom_range(63));
            endcase
            op.size = size_t'($urandom_range(3));
            // the unused extend code turns up now and then
            op.ext = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            pending_ops.push_back(op);
        end
    endtask

    task automatic note_mismatch(string what, rmme_res_t want, rmme_res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected value %h flags %h, got value %h flags %h",
                     $time, what, want.value, want.flags, got.value, got.flags);
    endtask

    // input side: new operation offered at the falling edge once the slot is free
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_tdata  <= pending_ops.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end

    // both channels sampled at the rising edge
    always @(posedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            expected_results.push_back(predict_result(merge_op_t'(s_tdata)));
            accepted_count++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata;
            if (expected_results.size() == 0) begin
                note_mismatch("result transfer with nothing pending", '0, got_res);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.value !== want_res.value)
                    note_mismatch("value mismatch", want_res, got_res);
                if (got_res.flags !== want_res.flags)
                    note_mismatch("flags mismatch", want_res, got_res);
            end
        end
    end

    // long receiver hold-off while the sender keeps offering, so the pipe backs up
    initial begin
        while (accepted_count < 80) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (60) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // field extremes and plain passes
        pending_ops.push_back(make_op('0, '0, 0, 0, 0, SIZE_B8, EXT_NONE));
        pending_ops.push_back(make_op('1, '0, 0, 63, 0, SIZE_B8, EXT_NONE));
        pending_ops.push_back(make_op('0, '1, 63, 63, 63, SIZE_B8, EXT_NONE));
        pending_ops.push_back(make_op(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                      8, 8, 0, SIZE_B8, EXT_NONE));
        // mask wraps past bit 63, field top beyond the word
        pending_ops.push_back(make_op(64'h5555_aaaa_5555_aaaa, '1, 60, 10, 3, SIZE_B8, EXT_ZERO));
        pending_ops.push_back(make_op(64'h5555_aaaa_5555_aaaa, '1, 60, 10, 3, SIZE_B8, EXT_SIGN));
        pending_ops.push_back(make_op(64'h0, 64'h1, 63, 1, 0, SIZE_B8, EXT_SIGN));
        // empty field at bit zero clears the value
        pending_ops.push_back(make_op(64'hdead_beef_cafe_f00d, '1, 0, 0, 5, SIZE_B8, EXT_ZERO));
        pending_ops.push_back(make_op(64'hdead_beef_cafe_f00d, '1, 0, 0, 5, SIZE_B8, EXT_SIGN));
        // zero count leaves the base as it was
        pending_ops.push_back(make_op(64'h8000_0000_0000_0001, '1, 20, 0, 7, SIZE_B8, EXT_NONE));
        // sign extension from a set and a clear field top, zero extension and the unused extend code
        pending_ops.push_back(make_op('0, 64'h80, 0, 8, 0, SIZE_B8, EXT_SIGN));
        pending_ops.push_back(make_op('1, 64'h7f, 0, 8, 0, SIZE_B8, EXT_SIGN));
        pending_ops.push_back(make_op('1, 64'h0, 4, 8, 0, SIZE_B8, EXT_ZERO));
        pending_ops.push_back(make_op('1, 64'h0, 4, 8, 0, SIZE_B8, 2'd3));
        pending_ops.push_back(make_op(64'h0, 64'h8000_0000, 32, 31, 1, SIZE_B8, EXT_SIGN));
        // each size, upper half cleared for four bytes
        pending_ops.push_back(make_op('1, 64'h1, 0, 8, 0, SIZE_B1, EXT_ZERO));
        pending_ops.push_back(make_op('1, 64'h3, 0, 8, 0, SIZE_B1, EXT_ZERO));
        pending_ops.push_back(make_op('1, 64'h8000, 0, 16, 0, SIZE_B2, EXT_SIGN));
        pending_ops.push_back(make_op('1, 64'h0, 0, 32, 0, SIZE_B4, EXT_NONE));
        pending_ops.push_back(make_op('1, 64'hffff_ffff, 0, 32, 32, SIZE_B4, EXT_SIGN));
        pending_ops.push_back(make_op(64'h00ff_0000_0000_0000, '0, 0, 16, 0, SIZE_B2, EXT_NONE));
        queue_random_ops(450);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 1; p <= 3; p++) begin
            while (pending_ops.size() != 0) @(posedge aclk);
            @(posedge aclk);
            sender_idle_pct    = (p == 1) ? 78 : (p == 3) ? 32 : 0;
            receiver_stall_pct = (p == 2) ? 78 : (p == 3) ? 32 : 0;
            queue_random_ops(450);
        end

        while (pending_ops.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
